// File: rtl/sctr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sctr_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned IdW   = 8;
  localparam int unsigned DataW = 64;

  localparam int unsigned NumCountersDefault = 32;

  localparam logic [CmdW-1:0] CmdAdd   = 3'd0;
  localparam logic [CmdW-1:0] CmdSub   = 3'd1;
  localparam logic [CmdW-1:0] CmdSet   = 3'd2;
  localparam logic [CmdW-1:0] CmdRead  = 3'd3;
  localparam logic [CmdW-1:0] CmdClear = 3'd4;

  localparam logic [DataW-1:0] S64Max = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] S64Min = {1'b1, {(DataW-1){1'b0}}};

endpackage

`default_nettype wire

// File: rtl/sctr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sctr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/saturating_counter_bank_unit.sv
// Bank of signed 64-bit saturating counters, selected by an identifier.
// Command words arrive on the slave stream: tuser carries the command code,
// tdata the counter identifier and the 64-bit operand. Add and subtract
// saturate at the signed 64-bit limits, set overwrites, clear zeroes every
// counter, and only a read produces a word on the master stream. An
// identifier at or above NUM_COUNTERS changes nothing and reads as zero.
// Each command is accepted in the idle state, which reads the counter memory
// (its read data is registered); its counter is then modified and written
// back in the write-back state. The block takes no new word until that is
// done, and a read result enters the output register as its write-back ends.
// The output register lets the block take the next command while a result
// waits; a read command that finds the output still full holds in its
// write-back cycle until the receiver takes the waiting word.
// Reset clears a valid bit per counter, so every counter reads as zero at
// once with no sweep of the memory; clear all does the same.
`timescale 1ns / 1ps
`default_nettype none

module saturating_counter_bank_unit #(
  parameter int unsigned NUM_COUNTERS = sctr_pkg::NumCountersDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // ctr_sel [7:0], operand_value [71:8]
  input  wire logic [2:0]  s_axis_tuser,  // cmd [2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [63:0] m_axis_tdata   // read_value [63:0]
);

  localparam int unsigned IdxW  = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam int unsigned DataW = sctr_pkg::DataW;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic                     state_q, state_d;
  logic [sctr_pkg::CmdW-1:0] cmd_q;
  logic [IdxW-1:0]          addr_q;
  logic                     id_valid_q;
  logic [DataW-1:0]         operand_q;
  logic [NUM_COUNTERS-1:0]  valid_q, valid_d;
  logic                     out_valid_q, out_valid_d;
  logic [DataW-1:0]         out_data_q;

  logic                     s_fire;
  logic                     in_id_valid;
  logic                     advance;
  logic                     is_read;
  logic                     ram_we;
  logic [DataW-1:0]         ram_rdata;
  logic [DataW-1:0]         stored;
  logic [DataW-1:0]         sum;
  logic [DataW-1:0]         diff;
  logic [DataW-1:0]         new_value;

  assign s_axis_tready = (state_q == StIdle);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_id_valid   = {1'b0, s_axis_tdata[7:0]} < 9'(NUM_COUNTERS);

  assign is_read = (cmd_q == sctr_pkg::CmdRead);
  assign advance = (state_q == StExec) && !(is_read && out_valid_q && !m_axis_tready);

  assign stored = (id_valid_q && valid_q[addr_q]) ? ram_rdata : '0;
  assign sum    = stored + operand_q;
  assign diff   = stored - operand_q;

  always_comb begin
    new_value = operand_q;
    case (cmd_q)
      sctr_pkg::CmdAdd: begin
        if ((stored[DataW-1] == operand_q[DataW-1]) && (sum[DataW-1] != stored[DataW-1])) begin
          new_value = stored[DataW-1] ? sctr_pkg::S64Min : sctr_pkg::S64Max;
        end else begin
          new_value = sum;
        end
      end
      sctr_pkg::CmdSub: begin
        if ((stored[DataW-1] != operand_q[DataW-1]) && (diff[DataW-1] != stored[DataW-1])) begin
          new_value = stored[DataW-1] ? sctr_pkg::S64Min : sctr_pkg::S64Max;
        end else begin
          new_value = diff;
        end
      end
      default: new_value = operand_q;
    endcase
  end

  assign ram_we = advance && id_valid_q &&
                  ((cmd_q == sctr_pkg::CmdAdd) || (cmd_q == sctr_pkg::CmdSub) ||
                   (cmd_q == sctr_pkg::CmdSet));

  sctr_ram #(
    .Width (DataW),
    .Depth (NUM_COUNTERS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (new_value),
    .re_i    (s_fire),
    .raddr_i (s_axis_tdata[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (s_fire) state_d = StExec;
      StExec:  if (advance) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (advance && (cmd_q == sctr_pkg::CmdClear)) begin
      valid_d = '0;
    end else if (ram_we) begin
      valid_d[addr_q] = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && is_read) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q      <= s_axis_tuser;
      addr_q     <= s_axis_tdata[IdxW-1:0];
      id_valid_q <= in_id_valid;
      operand_q  <= s_axis_tdata[71:8];
    end
    if (advance && is_read) begin
      out_data_q <= stored;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q == StExec) && !s_axis_tready)
    else $error("command accepted without entering write-back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (cmd_q == sctr_pkg::CmdClear)) |=> (valid_q == '0))
    else $error("clear all left a counter marked valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(advance && is_read))
    else $error("result word appeared without a read command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (id_valid_q && (state_q == StExec)))
    else $error("counter written outside write-back or with invalid id");

endmodule

`default_nettype wire

// File: bench/saturating_counter_bank_unit_tb.sv
`timescale 1ns / 1ps

module saturating_counter_bank_unit_tb;
  import sctr_pkg::*;

  localparam int unsigned NumCtr      = NumCountersDefault;
  localparam int unsigned RandomItems = 1400;
  localparam int unsigned TailItems   = 150;
  localparam int unsigned HoldAfter   = 500;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned SettleWait  = 20;
  localparam int unsigned CycleLimit  = 400000;

  localparam logic [CmdW-1:0] CmdSpareLo = CmdClear + 3'd1;
  localparam logic [CmdW-1:0] CmdSpareHi = '1;
  localparam logic [IdW-1:0]  IdTop      = '1;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [IdW-1:0]   id;
    logic [DataW-1:0] operand;
    logic             drain_first;
  } bank_cmd_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;  // ctr_sel [7:0], operand_value [71:8]
  logic [2:0]  s_axis_tuser  = '0;  // cmd [2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // read_value [63:0]

  bank_cmd_t        pending_cmds[$];
  logic [DataW-1:0] pending_reads[$];
  logic [DataW-1:0] bank_model[NumCtr];
  bank_cmd_t        cmd_on_bus;

  int unsigned accepted_count = 0;
  int unsigned reads_checked  = 0;
  int unsigned sat_hits       = 0;
  int unsigned clears_seen    = 0;
  int unsigned drain_points   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_stall     = 0;
  int unsigned recv_hold      = 0;
  bit          hold_done      = 1'b0;
  bit          calm_tail      = 1'b0;
  logic [DataW-1:0] read_want;

  saturating_counter_bank_unit #(
    .NUM_COUNTERS(NumCtr)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DataW-1:0] saturate_sum(logic [DataW-1:0] acc,
                                                    logic [DataW-1:0] delta,
                                                    bit subtract);
    logic [DataW:0] wide;
    if (subtract) begin
      wide = {acc[DataW-1], acc} - {delta[DataW-1], delta};
    end else begin
      wide = {acc[DataW-1], acc} + {delta[DataW-1], delta};
    end
    if (wide[DataW] != wide[DataW-1]) begin
      sat_hits++;
      return wide[DataW] ? S64Min : S64Max;
    end
    return wide[DataW-1:0];
  endfunction

  task automatic update_bank(bank_cmd_t c);
    bit id_ok;
    id_ok = c.id < NumCtr;
    case (c.cmd)
      CmdAdd: begin
        if (id_ok) bank_model[c.id] = saturate_sum(bank_model[c.id], c.operand, 1'b0);
      end
      CmdSub: begin
        if (id_ok) bank_model[c.id] = saturate_sum(bank_model[c.id], c.operand, 1'b1);
      end
      CmdSet: begin
        if (id_ok) bank_model[c.id] = c.operand;
      end
      CmdRead: begin
        pending_reads.push_back(id_ok ? bank_model[c.id] : '0);
      end
      CmdClear: begin
        clears_seen++;
        foreach (bank_model[i]) bank_model[i] = '0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_cmd(logic [CmdW-1:0] cmd, logic [IdW-1:0] id,
                           logic [DataW-1:0] operand, logic drain_first = 1'b0);
    bank_cmd_t c;
    c.cmd         = cmd;
    c.id          = id;
    c.operand     = operand;
    c.drain_first = drain_first;
    pending_cmds.push_back(c);
  endtask

  task automatic report_mismatch(string what, logic [DataW-1:0] got,
                                 logic [DataW-1:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [DataW-1:0] pick_operand();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = {32'd0, $urandom_range(0, 2000)} - 64'd1000;
      1: v = S64Max - $urandom_range(0, 3);
      2: v = S64Min + $urandom_range(0, 3);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [IdW-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return IdW'($urandom_range(0, 3));
    if (r < 80) return IdW'($urandom_range(0, NumCtr - 1));
    return IdW'($urandom_range(NumCtr, IdTop));
  endfunction

  function automatic logic [CmdW-1:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return CmdAdd;
    if (r < 50) return CmdSub;
    if (r < 62) return CmdSet;
    if (r < 92) return CmdRead;
    if (r < 95) return CmdClear;
    return CmdW'($urandom_range(CmdSpareLo, CmdSpareHi));
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        update_bank(cmd_on_bus);
        accepted_count <= accepted_count + 1;
      end
      calm_tail <= pending_cmds.size() < TailItems;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() == 0 ||
                     (pending_cmds[0].drain_first && pending_reads.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else if (!calm_tail && ((accepted_count / 100) % 4 != 3) &&
                     $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 10);
          s_axis_tvalid <= 1'b0;
        end else begin
          cmd_on_bus = pending_cmds.pop_front();
          if (cmd_on_bus.drain_first) drain_points++;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cmd_on_bus.operand, cmd_on_bus.id};
          s_axis_tuser  <= cmd_on_bus.cmd;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_reads.size() == 0) begin
          report_mismatch("word with no read pending", m_axis_tdata, '0);
        end else begin
          read_want = pending_reads.pop_front();
          reads_checked++;
          if (m_axis_tdata !== read_want) begin
            report_mismatch("read_value", m_axis_tdata, read_want);
          end
        end
      end
      if (!hold_done && accepted_count >= HoldAfter) begin
        hold_done = 1'b1;
        recv_hold = HoldCycles;
      end
      if (recv_hold != 0) begin
        recv_hold--;
        m_axis_tready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else if (!calm_tail && ((accepted_count / 100) % 4 != 3) &&
                   $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    foreach (bank_model[i]) bank_model[i] = '0;

    queue_cmd(CmdRead, 0, '0);
    queue_cmd(CmdSet, 0, S64Max);
    queue_cmd(CmdAdd, 0, 64'd1);
    queue_cmd(CmdRead, 0, '0);
    queue_cmd(CmdSet, 1, S64Min);
    queue_cmd(CmdSub, 1, 64'd1);
    queue_cmd(CmdRead, 1, '0);
    queue_cmd(CmdSub, 2, S64Min);
    queue_cmd(CmdRead, 2, '0);
    queue_cmd(CmdSet, 3, '1);
    queue_cmd(CmdSub, 3, S64Min);
    queue_cmd(CmdRead, 3, '0);
    queue_cmd(CmdAdd, 4, S64Min);
    queue_cmd(CmdAdd, 4, '1);
    queue_cmd(CmdRead, 4, '0);
    queue_cmd(CmdSet, IdW'(NumCtr - 1), 64'hA5A5_5A5A_0F0F_F0F0);
    queue_cmd(CmdRead, IdW'(NumCtr - 1), '0);
    queue_cmd(CmdSet, IdW'(NumCtr), 64'd5);
    queue_cmd(CmdAdd, IdTop, 64'd7);
    queue_cmd(CmdRead, IdW'(NumCtr), '0);
    queue_cmd(CmdRead, IdTop, '0);
    queue_cmd(CmdSpareLo, 0, 64'd9);
    queue_cmd(CmdSpareLo + 3'd1, 0, 64'd9);
    queue_cmd(CmdSpareHi, 0, 64'd9);
    queue_cmd(CmdRead, 0, '0);
    queue_cmd(CmdClear, 200, {$urandom, $urandom});
    queue_cmd(CmdRead, IdW'(NumCtr - 1), '0);

    for (int i = 0; i < RandomItems; i++) begin
      queue_cmd(pick_cmd(), pick_id(), pick_operand(), i == 0 || i == 800);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);

    $display("Covered %0d commands: %0d reads checked, %0d saturating updates, %0d clears.",
             accepted_count, reads_checked, sat_hits, clears_seen);
    $display("One receiver hold-off of %0d cycles; the sender drained %0d times; %0d cycles.",
             HoldCycles, drain_points, cycle_count);
    if (mismatch_count == 0 && pending_reads.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
